### design/assert_macros.svh
// assertion macros shared by the scheduler rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ftts_pkg.sv
// shared constants, codes and control structs of the tile scheduler
// no dependencies
`timescale 1ns / 1ps
package ftts_pkg;
    localparam int MAX_GROUPS_DEF = 1024;
    localparam int TIME_BITS_DEF  = 48;

    localparam int GRID_W     = 11;
    localparam int OFS_W      = 10;
    localparam int PER_W      = 30;
    localparam int TOL_W      = 8;
    localparam int UP_W       = 9;
    localparam int PU_W       = PER_W + UP_W;
    localparam int PU_SPLIT   = 20;
    localparam int Q8_SHIFT   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PER_W;

    localparam logic [UP_W-1:0]      Q8_ONE     = 9'd256;
    localparam logic [PER_W-1:0]     PERIOD_RST = 30'd16666667;
    localparam logic [TOL_W-1:0]     TOL_RST    = 8'd26;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 1'd1;
    localparam logic                 MODE_RESET = 1'b1;

    typedef struct packed {
        logic load;
        logic clr;
        logic stamp;
        logic prod_a;
        logic prod_b;
        logic prod_c;
        logic div_start;
        logic div_y;
        logic cap_x;
        logic cap_y;
        logic step;
        logic fast;
        logic calc_mod;
        logic calc_mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic fresh;
        logic tvalid;
        logic cont_slow;
        logic cont_fast;
        logic stuck;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_stat;
endpackage

### design/ftts_req_if.sv
// request channel: valid, ready and one request word
// depends on ftts_pkg
`timescale 1ns / 1ps
interface ftts_req_if #(
    parameter int TIME_BITS = ftts_pkg::TIME_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [TIME_BITS-1:0]         now_ns;
    logic [ftts_pkg::GRID_W-1:0]  total_groups_x;
    logic [ftts_pkg::GRID_W-1:0]  total_groups_y;

    modport source (output valid, mode, now_ns, total_groups_x, total_groups_y, input ready);
    modport sink   (input valid, mode, now_ns, total_groups_x, total_groups_y, output ready);
endinterface

### design/ftts_rsp_if.sv
// response channel: valid, ready and one tile word
// depends on ftts_pkg
`timescale 1ns / 1ps
interface ftts_rsp_if ();
    logic                         valid;
    logic                         ready;
    logic [ftts_pkg::GRID_W-1:0]  groups_per_tile_x;
    logic [ftts_pkg::GRID_W-1:0]  groups_per_tile_y;
    logic [ftts_pkg::OFS_W-1:0]   tile_offset_x;
    logic [ftts_pkg::OFS_W-1:0]   tile_offset_y;
    logic                         new_frame;

    modport source (output valid, groups_per_tile_x, groups_per_tile_y, tile_offset_x,
                    tile_offset_y, new_frame, input ready);
    modport sink   (input valid, groups_per_tile_x, groups_per_tile_y, tile_offset_x,
                    tile_offset_y, new_frame, output ready);
endinterface

### design/frame_time_tile_scheduler.sv
// top level of the frame-time tile scheduler: sequencer, datapath, checks
// depends on ftts_pkg, ftts_req_if, ftts_rsp_if, ftts_ctrl, ftts_datapath, assert_macros.svh
//
// channel   dir  handshake     word
// i_req     in   valid/ready   mode, now_ns, total_groups_x/y
// o_rsp     out  valid/ready   groups_per_tile_x/y, tile_offset_x/y, new_frame
// i_cfg_*   in   write enable  register index, data
//
// one request at a time; a reset word goes from decode straight back to idle
// a tile runs both serial divisions, D = clog2(MAX_GROUPS+1)+1 quotient bits each
// at a frame start each adjust step adds products, a compare and both divisions, up to twice the grid size
// synchronous active-low reset, no clearing pass; config is taken in any cycle
// a stalled output holds its word; the next request is taken while it waits
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frame_time_tile_scheduler #(
    parameter int MAX_GROUPS = ftts_pkg::MAX_GROUPS_DEF,
    parameter int TIME_BITS  = ftts_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ftts_req_if.sink                        i_req,
    ftts_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [ftts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ftts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    ftts_pkg::t_cmd  w_cmd;
    ftts_pkg::t_stat w_stat;

    ftts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ftts_datapath #(
        .MAX_GROUPS (MAX_GROUPS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_mode              (i_req.mode),
        .i_now_ns            (i_req.now_ns),
        .i_total_groups_x    (i_req.total_groups_x),
        .i_total_groups_y    (i_req.total_groups_y),
        .o_valid             (o_rsp.valid),
        .i_ready             (o_rsp.ready),
        .o_groups_per_tile_x (o_rsp.groups_per_tile_x),
        .o_groups_per_tile_y (o_rsp.groups_per_tile_y),
        .o_tile_offset_x     (o_rsp.tile_offset_x),
        .o_tile_offset_y     (o_rsp.tile_offset_y),
        .o_new_frame         (o_rsp.new_frame)
    );

    `ASSERT_CLK(a_one_in_flight, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> !i_req.ready, "request taken while busy")
    `ASSERT_CLK(a_div_idle, i_clk, i_rst_n, w_cmd.div_start |-> !w_stat.div_busy, "divider restarted while busy")
    `ASSERT_CLK(a_emit_free, i_clk, i_rst_n, w_cmd.emit |-> w_stat.out_free, "output word overwritten")
    `ASSERT_CLK(a_valid_src, i_clk, i_rst_n, $rose(o_rsp.valid) |-> $past(w_cmd.emit), "output valid without a tile")
endmodule

### design/ftts_divider.sv
// restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
module ftts_divider #(
    parameter int DW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_quo;
    logic [DW-1:0]   r_div;
    logic [DW:0]     w_trial;
    logic            w_ge;
    logic [DW:0]     w_diff;
    logic [DW-1:0]   n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

### design/ftts_datapath.sv
// scheduler datapath: state, config, timing products, tile math, output word
// depends on ftts_pkg and ftts_divider
`timescale 1ns / 1ps
module ftts_datapath #(
    parameter int MAX_GROUPS = ftts_pkg::MAX_GROUPS_DEF,
    parameter int TIME_BITS  = ftts_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ftts_pkg::t_cmd                   i_cmd,
    output ftts_pkg::t_stat                  o_stat,
    input  logic                             i_cfg_we,
    input  logic [ftts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ftts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_mode,
    input  logic [TIME_BITS-1:0]             i_now_ns,
    input  logic [ftts_pkg::GRID_W-1:0]      i_total_groups_x,
    input  logic [ftts_pkg::GRID_W-1:0]      i_total_groups_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ftts_pkg::GRID_W-1:0]      o_groups_per_tile_x,
    output logic [ftts_pkg::GRID_W-1:0]      o_groups_per_tile_y,
    output logic [ftts_pkg::OFS_W-1:0]       o_tile_offset_x,
    output logic [ftts_pkg::OFS_W-1:0]       o_tile_offset_y,
    output logic                             o_new_frame
);
    localparam int CW    = $clog2(MAX_GROUPS + 1);
    localparam int IW    = $clog2(MAX_GROUPS);
    localparam int DW    = CW + 1;
    localparam int NW    = 2 * CW;
    localparam int CMPW  = (CW > ftts_pkg::GRID_W) ? CW : ftts_pkg::GRID_W;
    localparam int HB    = (TIME_BITS + 1) / 2;
    localparam int HW    = TIME_BITS - HB;
    localparam int EUL_W = HB + ftts_pkg::UP_W;
    localparam int EUH_W = HW + ftts_pkg::UP_W;
    localparam int PNL_W = ftts_pkg::PU_SPLIT + NW;
    localparam int PNH_W = ftts_pkg::PU_W - ftts_pkg::PU_SPLIT + NW;
    localparam int P8N_W = ftts_pkg::PER_W + NW;
    localparam int WA    = TIME_BITS + ftts_pkg::UP_W;
    localparam int WB    = ftts_pkg::PU_W + NW;
    localparam int WW    = ((WA > WB) ? WA : WB) + 1;

    logic [ftts_pkg::PER_W-1:0] r_period;
    logic [ftts_pkg::TOL_W-1:0] r_tol;
    logic [CW-1:0]        r_cx, r_cy;
    logic [IW-1:0]        r_ix, r_iy;
    logic [TIME_BITS-1:0] r_last;
    logic                 r_tvalid;
    logic                 r_mode;
    logic [TIME_BITS-1:0] r_now;
    logic [CW-1:0]        r_gx, r_gy;
    logic [TIME_BITS-1:0] r_e;
    logic [NW-1:0]        r_n;
    logic [ftts_pkg::PU_W-1:0] r_pu;
    logic [EUL_W-1:0]     r_eul;
    logic [EUH_W-1:0]     r_euh;
    logic [PNL_W-1:0]     r_pnl;
    logic [PNH_W-1:0]     r_pnh;
    logic [P8N_W-1:0]     r_p8n;
    logic [WW-1:0]        r_lhs, r_rhs;
    logic [CW-1:0]        r_px, r_py;
    logic [CW-1:0]        r_mx, r_my;
    logic [NW-1:0]        r_ox, r_oy;
    logic                 r_ov;
    logic [ftts_pkg::GRID_W-1:0] r_o_px, r_o_py;
    logic [ftts_pkg::OFS_W-1:0]  r_o_ox, r_o_oy;
    logic                 r_o_new;

    logic [CW-1:0]        w_gx, w_gy;
    logic [ftts_pkg::UP_W-1:0] w_up;
    logic                 w_fresh;
    logic                 w_dir_y;
    logic                 w_stuck;
    logic [CW-1:0]        n_cx, n_cy;
    logic [DW-1:0]        w_dividend, w_divisor;
    logic [DW-1:0]        w_quo;
    logic                 w_div_busy, w_div_done;
    logic [CW:0]          w_sx, w_sy;
    logic [CW-1:0]        w_ix1, w_iy1;
    logic [CW-1:0]        n_ix, n_iy;
    logic                 w_out_free;

    // grid clamp to 1..MAX_GROUPS
    always_comb begin
        if (i_total_groups_x == '0) begin
            w_gx = CW'(1);
        end else if (CMPW'(i_total_groups_x) > CMPW'(MAX_GROUPS)) begin
            w_gx = CW'(MAX_GROUPS);
        end else begin
            w_gx = CW'(i_total_groups_x);
        end
        if (i_total_groups_y == '0) begin
            w_gy = CW'(1);
        end else if (CMPW'(i_total_groups_y) > CMPW'(MAX_GROUPS)) begin
            w_gy = CW'(MAX_GROUPS);
        end else begin
            w_gy = CW'(i_total_groups_y);
        end
    end

    assign w_up    = ftts_pkg::Q8_ONE + ftts_pkg::UP_W'(r_tol);
    assign w_fresh = (r_ix == '0) && (r_iy == '0);
    assign w_dir_y = (r_px <= r_py);

    // one count step of the adjust loops
    always_comb begin
        n_cx    = r_cx;
        n_cy    = r_cy;
        w_stuck = 1'b0;
        if (!i_cmd.fast) begin
            if (w_dir_y && (r_cy < r_gy)) begin
                n_cy = r_cy + 1'b1;
            end else if (!w_dir_y && (r_cx < r_gx)) begin
                n_cx = r_cx + 1'b1;
            end else if (w_dir_y && (r_cx < r_gx)) begin
                n_cx = r_cx + 1'b1;
            end else if (!w_dir_y && (r_cy < r_gy)) begin
                n_cy = r_cy + 1'b1;
            end else begin
                w_stuck = 1'b1;
            end
        end else begin
            if (w_dir_y && (r_cy > CW'(1))) begin
                n_cy = r_cy - 1'b1;
            end else if (!w_dir_y && (r_cx > CW'(1))) begin
                n_cx = r_cx - 1'b1;
            end else if (w_dir_y && (r_cx > CW'(1))) begin
                n_cx = r_cx - 1'b1;
            end else if (!w_dir_y && (r_cy > CW'(1))) begin
                n_cy = r_cy - 1'b1;
            end else begin
                w_stuck = 1'b1;
            end
        end
    end

    // ceil division operands
    always_comb begin
        if (i_cmd.div_y) begin
            w_dividend = DW'(r_gy) + DW'(r_cy) - DW'(1);
            w_divisor  = DW'(r_cy);
        end else begin
            w_dividend = DW'(r_gx) + DW'(r_cx) - DW'(1);
            w_divisor  = DW'(r_cx);
        end
    end

    ftts_divider #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // center-first offset index and index advance
    always_comb begin
        w_sx = (CW + 1)'(r_ix) + (CW + 1)'(r_cx >> 1);
        w_sy = (CW + 1)'(r_iy) + (CW + 1)'(r_cy >> 1);
        if (w_sx >= (CW + 1)'(r_cx)) begin
            w_sx = w_sx - (CW + 1)'(r_cx);
        end
        if (w_sy >= (CW + 1)'(r_cy)) begin
            w_sy = w_sy - (CW + 1)'(r_cy);
        end
        w_ix1 = CW'(r_ix) + CW'(1);
        n_ix  = (w_ix1 == r_cx) ? '0 : w_ix1;
        w_iy1 = CW'(r_iy) + ((n_ix == '0) ? CW'(1) : CW'(0));
        n_iy  = (w_iy1 == r_cy) ? '0 : w_iy1;
    end

    assign w_out_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= ftts_pkg::PERIOD_RST;
            r_tol    <= ftts_pkg::TOL_RST;
            r_cx     <= CW'(1);
            r_cy     <= CW'(1);
            r_ix     <= '0;
            r_iy     <= '0;
            r_last   <= '0;
            r_tvalid <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ftts_pkg::CFG_PERIOD: r_period <= i_cfg_data[ftts_pkg::PER_W-1:0];
                    ftts_pkg::CFG_TOL:    r_tol    <= i_cfg_data[ftts_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr) begin
                r_ix     <= '0;
                r_iy     <= '0;
                r_tvalid <= 1'b0;
            end
            if (i_cmd.stamp) begin
                r_last   <= r_now;
                r_tvalid <= 1'b1;
            end
            if (i_cmd.step && !w_stuck) begin
                r_cx <= n_cx;
                r_cy <= n_cy;
            end
            if (i_cmd.emit) begin
                r_ix <= n_ix[IW-1:0];
                r_iy <= n_iy[IW-1:0];
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_now  <= i_now_ns;
            r_gx   <= w_gx;
            r_gy   <= w_gy;
        end
        if (i_cmd.stamp) begin
            r_e <= r_now - r_last;
        end
        if (i_cmd.prod_a) begin
            r_n   <= NW'(r_cx) * NW'(r_cy);
            r_pu  <= ftts_pkg::PU_W'(r_period) * ftts_pkg::PU_W'(w_up);
            r_eul <= EUL_W'(r_e[HB-1:0]) * EUL_W'(w_up);
            r_euh <= EUH_W'(r_e[TIME_BITS-1:HB]) * EUH_W'(w_up);
        end
        if (i_cmd.prod_b) begin
            r_pnl <= PNL_W'(r_pu[ftts_pkg::PU_SPLIT-1:0]) * PNL_W'(r_n);
            r_pnh <= PNH_W'(r_pu[ftts_pkg::PU_W-1:ftts_pkg::PU_SPLIT]) * PNH_W'(r_n);
            r_p8n <= P8N_W'(r_period) * P8N_W'(r_n);
        end
        if (i_cmd.prod_c) begin
            if (i_cmd.fast) begin
                r_lhs <= (WW'(r_euh) << HB) + WW'(r_eul);
                r_rhs <= WW'(r_p8n) << ftts_pkg::Q8_SHIFT;
            end else begin
                r_lhs <= WW'(r_e) << ftts_pkg::Q8_SHIFT;
                r_rhs <= (WW'(r_pnh) << ftts_pkg::PU_SPLIT) + WW'(r_pnl);
            end
        end
        if (i_cmd.cap_x) begin
            r_px <= w_quo[CW-1:0];
        end
        if (i_cmd.cap_y) begin
            r_py <= w_quo[CW-1:0];
        end
        if (i_cmd.calc_mod) begin
            r_mx <= w_sx[CW-1:0];
            r_my <= w_sy[CW-1:0];
        end
        if (i_cmd.calc_mul) begin
            r_ox <= NW'(r_px) * NW'(r_mx);
            r_oy <= NW'(r_py) * NW'(r_my);
        end
        if (i_cmd.emit) begin
            r_o_px  <= ftts_pkg::GRID_W'(r_px);
            r_o_py  <= ftts_pkg::GRID_W'(r_py);
            r_o_ox  <= ftts_pkg::OFS_W'(r_ox);
            r_o_oy  <= ftts_pkg::OFS_W'(r_oy);
            r_o_new <= w_fresh;
        end
    end

    always_comb begin
        o_stat.mode      = (r_mode == ftts_pkg::MODE_RESET);
        o_stat.fresh     = w_fresh;
        o_stat.tvalid    = r_tvalid;
        o_stat.cont_slow = (r_lhs > r_rhs);
        o_stat.cont_fast = (r_lhs < r_rhs);
        o_stat.stuck     = w_stuck;
        o_stat.div_busy  = w_div_busy;
        o_stat.div_done  = w_div_done;
        o_stat.out_free  = w_out_free;
    end

    assign o_valid             = r_ov;
    assign o_groups_per_tile_x = r_o_px;
    assign o_groups_per_tile_y = r_o_py;
    assign o_tile_offset_x     = r_o_ox;
    assign o_tile_offset_y     = r_o_oy;
    assign o_new_frame         = r_o_new;
endmodule

### design/ftts_ctrl.sv
// scheduler sequencer: request decode, adjust loops, tile math, output hand-off
// depends on ftts_pkg
`timescale 1ns / 1ps
module ftts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  ftts_pkg::t_stat i_stat,
    output ftts_pkg::t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_PA   = 4'd2;
    localparam logic [3:0] S_PB   = 4'd3;
    localparam logic [3:0] S_PC   = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_DX   = 4'd6;
    localparam logic [3:0] S_WX   = 4'd7;
    localparam logic [3:0] S_DY   = 4'd8;
    localparam logic [3:0] S_WY   = 4'd9;
    localparam logic [3:0] S_STEP = 4'd10;
    localparam logic [3:0] S_MOD  = 4'd11;
    localparam logic [3:0] S_MUL  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_fast, n_fast;
    logic       r_loop, n_loop;

    always_comb begin
        n_state = r_state;
        n_fast  = r_fast;
        n_loop  = r_loop;
        o_cmd   = '0;
        o_cmd.fast  = r_fast;
        o_req_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_loop = 1'b0;
                if (i_stat.mode) begin
                    o_cmd.clr = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.fresh) begin
                    o_cmd.stamp = 1'b1;
                    if (i_stat.tvalid) begin
                        n_fast  = 1'b0;
                        n_loop  = 1'b1;
                        n_state = S_PA;
                    end else begin
                        n_state = S_DX;
                    end
                end else begin
                    n_state = S_DX;
                end
            end
            S_PA: begin
                o_cmd.prod_a = 1'b1;
                n_state = S_PB;
            end
            S_PB: begin
                o_cmd.prod_b = 1'b1;
                n_state = S_PC;
            end
            S_PC: begin
                o_cmd.prod_c = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_fast ? i_stat.cont_fast : i_stat.cont_slow) begin
                    n_state = S_DX;
                end else if (!r_fast) begin
                    n_fast  = 1'b1;
                    n_state = S_PA;
                end else begin
                    n_loop  = 1'b0;
                    n_state = S_DX;
                end
            end
            S_DX: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WX;
            end
            S_WX: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_x = 1'b1;
                    n_state = S_DY;
                end
            end
            S_DY: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_y = 1'b1;
                n_state = S_WY;
            end
            S_WY: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_y = 1'b1;
                    n_state = r_loop ? S_STEP : S_MOD;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (!i_stat.stuck) begin
                    n_state = S_PA;
                end else if (!r_fast) begin
                    n_fast  = 1'b1;
                    n_state = S_PA;
                end else begin
                    n_loop  = 1'b0;
                    n_state = S_DX;
                end
            end
            S_MOD: begin
                o_cmd.calc_mod = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fast  <= 1'b0;
            r_loop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fast  <= n_fast;
            r_loop  <= n_loop;
        end
    end
endmodule

### bench/frame_time_tile_scheduler_chk.sv
// checker of the tile scheduler: watches both channels and the config port,
// predicts every tile word and compares it as a whole
// depends on ftts_pkg, ftts_req_if, ftts_rsp_if
`timescale 1ns / 1ps
module frame_time_tile_scheduler_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ftts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ftts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ftts_req_if                             i_req,
    ftts_rsp_if                             i_rsp,
    output int                              o_errors,
    output int                              o_pending
);
    localparam int GRID_MAX = ftts_pkg::MAX_GROUPS_DEF;

    typedef struct packed {
        logic [ftts_pkg::GRID_W-1:0] gpt_x;
        logic [ftts_pkg::GRID_W-1:0] gpt_y;
        logic [ftts_pkg::OFS_W-1:0]  ofs_x;
        logic [ftts_pkg::OFS_W-1:0]  ofs_y;
        logic                        frame_start;
    } t_tile;

    t_tile tile_q[$];

    logic [ftts_pkg::PER_W-1:0]         period;
    logic [ftts_pkg::TOL_W-1:0]         tol;
    int unsigned                        idx_x, idx_y, cnt_x, cnt_y;
    logic [ftts_pkg::TIME_BITS_DEF-1:0] frame_start_ns;
    logic                               frame_start_known;

    function automatic int unsigned div_up(int unsigned a, int unsigned c);
        return (a + c - 1) / c;
    endfunction

    function automatic int unsigned grid_clamp(logic [ftts_pkg::GRID_W-1:0] v);
        if (v == 0) return 1;
        if (v > GRID_MAX) return GRID_MAX;
        return v;
    endfunction

    task automatic retune_counts(logic [63:0] el, int unsigned gx, int unsigned gy);
        logic [63:0] up, p, n;
        bit          grow_y;
        up = 64'd256 + tol;
        p = period;
        forever begin
            n = cnt_x * cnt_y;
            if (el * 64'd256 <= up * p * n) break;
            grow_y = div_up(gx, cnt_x) <= div_up(gy, cnt_y);
            if (grow_y && cnt_y + 1 <= gy) cnt_y++;
            else if (!grow_y && cnt_x + 1 <= gx) cnt_x++;
            else if (grow_y && cnt_x + 1 <= gx) cnt_x++;
            else if (!grow_y && cnt_y + 1 <= gy) cnt_y++;
            else break;
        end
        forever begin
            n = cnt_x * cnt_y;
            if (el * up >= 64'd256 * p * n) break;
            grow_y = div_up(gx, cnt_x) <= div_up(gy, cnt_y);
            if (grow_y && cnt_y > 1) cnt_y--;
            else if (!grow_y && cnt_x > 1) cnt_x--;
            else if (grow_y && cnt_x > 1) cnt_x--;
            else if (!grow_y && cnt_y > 1) cnt_y--;
            else break;
        end
    endtask

    task automatic schedule_tile(logic [ftts_pkg::TIME_BITS_DEF-1:0] now,
                                 logic [ftts_pkg::GRID_W-1:0] tgx,
                                 logic [ftts_pkg::GRID_W-1:0] tgy);
        int unsigned                        gx, gy, px, py;
        t_tile                              t;
        logic [ftts_pkg::TIME_BITS_DEF-1:0] el;
        gx = grid_clamp(tgx);
        gy = grid_clamp(tgy);
        t.frame_start = (idx_x == 0 && idx_y == 0);
        if (t.frame_start) begin
            el = now - frame_start_ns;
            if (frame_start_known) retune_counts(64'(el), gx, gy);
            frame_start_ns = now;
            frame_start_known = 1'b1;
        end
        px = div_up(gx, cnt_x);
        py = div_up(gy, cnt_y);
        t.gpt_x = px[ftts_pkg::GRID_W-1:0];
        t.gpt_y = py[ftts_pkg::GRID_W-1:0];
        t.ofs_x = ftts_pkg::OFS_W'(px * ((idx_x + cnt_x / 2) % cnt_x));
        t.ofs_y = ftts_pkg::OFS_W'(py * ((idx_y + cnt_y / 2) % cnt_y));
        idx_x = (idx_x + 1) % cnt_x;
        idx_y = (idx_y + (idx_x == 0 ? 1 : 0)) % cnt_y;
        tile_q.insert(tile_q.size(), t);
    endtask

    always @(posedge i_clk) begin
        t_tile got, want;
        if (!i_rst_n) begin
            period = ftts_pkg::PERIOD_RST;
            tol = ftts_pkg::TOL_RST;
            idx_x = 0;
            idx_y = 0;
            cnt_x = 1;
            cnt_y = 1;
            frame_start_ns = '0;
            frame_start_known = 1'b0;
            tile_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ftts_pkg::CFG_PERIOD)
                    period = i_cfg_data[ftts_pkg::PER_W-1:0];
                else if (i_cfg_idx == ftts_pkg::CFG_TOL)
                    tol = i_cfg_data[ftts_pkg::TOL_W-1:0];
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.groups_per_tile_x, i_rsp.groups_per_tile_y, i_rsp.tile_offset_x,
                        i_rsp.tile_offset_y, i_rsp.new_frame};
                if (tile_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected tile word %p", got);
                end else begin
                    want = tile_q[0];
                    tile_q.delete(0);
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10) $display("tile mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.mode == ftts_pkg::MODE_RESET) begin
                    idx_x = 0;
                    idx_y = 0;
                    frame_start_known = 1'b0;
                end else begin
                    schedule_tile(i_req.now_ns, i_req.total_groups_x, i_req.total_groups_y);
                end
            end
        end
        o_pending = tile_q.size();
    end
endmodule

### bench/frame_time_tile_scheduler_tb.sv
// testbench top of the tile scheduler: clock, reset, config phases, request
// stimulus with random idling and the verdict
// depends on ftts_pkg, ftts_req_if, ftts_rsp_if, frame_time_tile_scheduler, frame_time_tile_scheduler_chk
`timescale 1ns / 1ps
module frame_time_tile_scheduler_tb;
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [ftts_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [ftts_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              errors, pending;
    int                              send_idle_pct, rsp_stall_pct;
    int                              hold_req, hold_seen, hold_left;
    logic [47:0]                     now_ns;
    logic [ftts_pkg::PER_W-1:0]      cur_period;

    ftts_req_if #(.TIME_BITS(ftts_pkg::TIME_BITS_DEF)) req_ch ();
    ftts_rsp_if rsp_ch ();

    frame_time_tile_scheduler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    frame_time_tile_scheduler_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls plus long counted hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    task automatic send_word(logic mode, logic [47:0] now, logic [ftts_pkg::GRID_W-1:0] gx,
                             logic [ftts_pkg::GRID_W-1:0] gy);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.now_ns <= now;
        req_ch.total_groups_x <= gx;
        req_ch.total_groups_y <= gy;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_block();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ftts_pkg::CFG_IDX_W-1:0] idx,
                             logic [ftts_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [ftts_pkg::GRID_W-1:0] pick_grid();
        int k;
        k = $urandom_range(99);
        if (k < 80) return ftts_pkg::GRID_W'($urandom_range(1, 6));
        if (k < 92) return ftts_pkg::GRID_W'($urandom_range(0, 2047));
        case ($urandom_range(2))
            0: return ftts_pkg::GRID_W'(0);
            1: return ftts_pkg::GRID_W'(ftts_pkg::MAX_GROUPS_DEF);
            default: return ftts_pkg::GRID_W'(2047);
        endcase
    endfunction

    task automatic advance_time();
        case ($urandom_range(5))
            0: ;
            1: now_ns += 48'(cur_period) * $urandom_range(0, 6);
            2: now_ns += 48'(cur_period) * $urandom_range(0, 40);
            3: now_ns += $urandom_range(0, 5000);
            4: now_ns += 48'($urandom);
            default: now_ns = {16'($urandom), 32'($urandom)};
        endcase
    endtask

    initial begin
        logic [ftts_pkg::PER_W-1:0] periods[4];
        logic [ftts_pkg::TOL_W-1:0] tols[4];
        int                         idle_set[4], stall_set[4];
        periods = '{30'd1, 30'd1000000000, 30'd2000, 30'd50000};
        tols = '{8'd0, 8'd255, 8'd26, 8'd128};
        idle_set = '{0, 64, 0, 24};
        stall_set = '{0, 0, 64, 24};
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = ftts_pkg::CFG_PERIOD;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = ~ftts_pkg::MODE_RESET;
        req_ch.now_ns = '0;
        req_ch.total_groups_x = 1;
        req_ch.total_groups_y = 1;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        now_ns = '0;
        cur_period = ftts_pkg::PERIOD_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clamping, wrap, slow and fast frames, shrinking grid, reset word
        send_word(~ftts_pkg::MODE_RESET, 48'd0, 11'd4, 11'd3);
        send_word(~ftts_pkg::MODE_RESET, 48'd100, 11'd4, 11'd3);
        send_word(~ftts_pkg::MODE_RESET, 48'd500000000, 11'd4, 11'd3);
        repeat (6) send_word(~ftts_pkg::MODE_RESET, 48'd500000100, 11'd4, 11'd3);
        send_word(~ftts_pkg::MODE_RESET, 48'd500000200, 11'd1, 11'd1);
        send_word(~ftts_pkg::MODE_RESET, 48'd500000300, 11'd0, 11'd0);
        send_word(ftts_pkg::MODE_RESET, 48'hFFFF_FFFF_FFFF, 11'd2047, 11'd2047);
        send_word(~ftts_pkg::MODE_RESET, 48'hFFFF_FFFF_FF00, 11'd2047, 11'd1024);
        send_word(~ftts_pkg::MODE_RESET, 48'h0000_0000_0100, 11'd2, 11'd2);
        send_word(~ftts_pkg::MODE_RESET, 48'h0000_0000_0200, 11'd1024, 11'd2);
        send_word(ftts_pkg::MODE_RESET, 48'd0, 11'd1, 11'd1);
        drain_block();
        write_reg(ftts_pkg::CFG_PERIOD, '0);
        write_reg(ftts_pkg::CFG_TOL, 8'd255);
        cur_period = '0;
        send_word(~ftts_pkg::MODE_RESET, 48'd1000, 11'd3, 11'd2);
        send_word(~ftts_pkg::MODE_RESET, 48'd1000, 11'd3, 11'd2);
        send_word(~ftts_pkg::MODE_RESET, 48'd1001, 11'd3, 11'd2);
        send_word(ftts_pkg::MODE_RESET, 48'd0, 11'd1, 11'd1);

        for (int ph = 0; ph < 4; ph++) begin
            drain_block();
            cur_period = periods[ph];
            write_reg(ftts_pkg::CFG_PERIOD, ftts_pkg::CFG_DATA_W'(periods[ph]));
            write_reg(ftts_pkg::CFG_TOL, tols[ph]);
            send_idle_pct = idle_set[ph];
            rsp_stall_pct = stall_set[ph];
            for (int i = 0; i < 30; i++) begin
                if (i == 10) hold_req++;
                if (i == 20) begin
                    req_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                advance_time();
                if ($urandom_range(99) < 8)
                    send_word(ftts_pkg::MODE_RESET, {16'($urandom), 32'($urandom)},
                              pick_grid(), pick_grid());
                else
                    send_word(~ftts_pkg::MODE_RESET, now_ns, pick_grid(), pick_grid());
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #500ms;
        $display("FAIL");
        $finish;
    end
endmodule
